FILE: rtl/rdq_pkg.sv
// ---------------------------------------------------------------------------
// rdq_pkg
// Shared widths, operation and status codes, and the command and status
// groups that pass between the deque controller and its datapath.
// ---------------------------------------------------------------------------
package rdq_pkg;

  localparam int DATA_W        = 64;
  localparam int OP_W          = 3;
  localparam int ST_W          = 2;
  localparam int DEPTH_DEFAULT = 1024;

  // operation codes
  localparam logic [OP_W-1:0] OP_PUSH_L = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_R = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_L  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_R  = 3'd3;
  localparam logic [OP_W-1:0] OP_REV    = 3'd4;

  // status codes
  localparam logic [ST_W-1:0] ST_OK    = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;      // latch the accepted input beat
    logic exec;      // update pointers, write or read the ring
    logic capture;   // take the ring read data into an end register
    logic load_out;  // load the output register
  } rdq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_read; // this operation must refetch an end value
    logic out_free;  // output register can take a new beat
  } rdq_stat_t;

endpackage

FILE: rtl/reversible_deque.sv
// ---------------------------------------------------------------------------
// reversible_deque
// Bounded double-ended queue of 64-bit values held in a ring memory, with a
// constant-time reverse of the two ends.
// ---------------------------------------------------------------------------
// result beat: the input beat is latched, executed, then loaded into the
//   output register; a pop that leaves the deque non-empty adds a step, the
//   registered read of the ring memory that refetches the end
// the next input beat waits until the previous result is in the output register
// a new input beat is taken while the previous result still waits at the output
// reset clears pointers, count, reverse flag and valids; ring contents are
//   left as they are and need no clearing pass
module reversible_deque #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [rdq_pkg::OP_W-1:0]          op,
  input  logic signed [rdq_pkg::DATA_W-1:0] value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [rdq_pkg::DATA_W-1:0] popped_value,
  output logic signed [rdq_pkg::DATA_W-1:0] left_value,
  output logic signed [rdq_pkg::DATA_W-1:0] right_value,
  output logic [$clog2(DEPTH+1)-1:0]        count,
  output logic                              is_empty,
  output logic [rdq_pkg::ST_W-1:0]          status
);

  rdq_pkg::rdq_cmd_t  cmd;
  rdq_pkg::rdq_stat_t stat;

  // operation sequencer
  rdq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ring, pointers and output register
  rdq_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .op           (op),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .popped_value (popped_value),
    .left_value   (left_value),
    .right_value  (right_value),
    .count        (count),
    .is_empty     (is_empty),
    .status       (status)
  );

endmodule

FILE: rtl/rdq_ram.sv
// ---------------------------------------------------------------------------
// rdq_ram
// Generic single-write, single-read memory with a registered read port.
// ---------------------------------------------------------------------------
module rdq_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/rdq_ctrl.sv
// ---------------------------------------------------------------------------
// rdq_ctrl
// Sequencer for one deque operation: accept, execute, optional ring read,
// then hand the result to the output register.
// ---------------------------------------------------------------------------
module rdq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  rdq_pkg::rdq_stat_t stat,
  output rdq_pkg::rdq_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RD,
    S_FIN
  } state_t;

  state_t state;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= stat.need_read ? S_RD : S_FIN;
        end
        S_RD: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (stat.out_free) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // commands decoded from state
  assign in_stall     = (state != S_IDLE);
  assign cmd.load     = (state == S_IDLE) && in_valid;
  assign cmd.exec     = (state == S_EXEC);
  assign cmd.capture  = (state == S_RD);
  assign cmd.load_out = (state == S_FIN) && stat.out_free;

endmodule

FILE: rtl/rdq_dp.sv
// ---------------------------------------------------------------------------
// rdq_dp
// Deque datapath: ring pointers, count, reverse flag, physical end values,
// the ring memory and the output register.
// ---------------------------------------------------------------------------
module rdq_dp #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  rdq_pkg::rdq_cmd_t                cmd,
  output rdq_pkg::rdq_stat_t               stat,
  input  logic [rdq_pkg::OP_W-1:0]         op,
  input  logic signed [rdq_pkg::DATA_W-1:0] value,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [rdq_pkg::DATA_W-1:0] popped_value,
  output logic signed [rdq_pkg::DATA_W-1:0] left_value,
  output logic signed [rdq_pkg::DATA_W-1:0] right_value,
  output logic [$clog2(DEPTH+1)-1:0]       count,
  output logic                             is_empty,
  output logic [rdq_pkg::ST_W-1:0]         status
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int DW = rdq_pkg::DATA_W;

  // latched input beat
  logic [rdq_pkg::OP_W-1:0] op_q;
  logic [DW-1:0]            val_q;

  // deque state
  logic [AW-1:0] head;
  logic [CW-1:0] cnt;
  logic          rev;
  logic [DW-1:0] pl;       // value at physical left end
  logic [DW-1:0] pr;       // value at physical right end
  logic          rd_right; // pending read refills the right end
  logic [DW-1:0] pop_q;
  logic [rdq_pkg::ST_W-1:0] st_q;

  // ring memory
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  // decode
  logic          is_push;
  logic          is_pop;
  logic          to_right;
  logic          from_right;
  logic          full;
  logic          empty;
  logic [AW-1:0] head_dec;
  logic [AW-1:0] head_inc;
  logic [AW-1:0] tail_next;
  logic [AW-1:0] tail_prev;
  logic [CW-1:0] cnt_m2;

  // add two in-range offsets modulo DEPTH
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  // operation decode and ring addresses
  always_comb begin
    is_push    = (op_q == rdq_pkg::OP_PUSH_L) || (op_q == rdq_pkg::OP_PUSH_R);
    is_pop     = (op_q == rdq_pkg::OP_POP_L) || (op_q == rdq_pkg::OP_POP_R);
    to_right   = (op_q == rdq_pkg::OP_PUSH_R) ^ rev;
    from_right = (op_q == rdq_pkg::OP_POP_R) ^ rev;
    full       = (cnt == CW'(DEPTH));
    empty      = (cnt == '0);
    head_dec   = (head == '0) ? AW'(DEPTH - 1) : head - AW'(1);
    head_inc   = wrap_add(head, AW'(1));
    cnt_m2     = cnt - CW'(2);
    tail_next  = wrap_add(head, cnt[AW-1:0]);
    tail_prev  = wrap_add(head, cnt_m2[AW-1:0]);
  end

  // ring access issued in the execute step
  always_comb begin
    mem_we         = cmd.exec && is_push && !full;
    mem_waddr      = to_right ? tail_next : head_dec;
    mem_re         = cmd.exec && is_pop && (cnt > CW'(1));
    mem_raddr      = from_right ? tail_prev : head_inc;
    stat.need_read = is_pop && (cnt > CW'(1));
    stat.out_free  = !out_valid || !out_stall;
  end

  rdq_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (val_q),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // input latch, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= op;
      val_q <= value;
    end
  end

  // pointers, count, reverse flag
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      cnt  <= '0;
      rev  <= 1'b0;
    end else if (cmd.exec) begin
      if (is_push && !full) begin
        cnt <= cnt + CW'(1);
        if (!to_right) head <= head_dec;
      end else if (is_pop && !empty) begin
        cnt <= cnt - CW'(1);
        if (!from_right) head <= head_inc;
      end else if (op_q == rdq_pkg::OP_REV) begin
        rev <= !rev;
      end
    end
  end

  // end values, popped value and status
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_q <= '0;
      st_q  <= rdq_pkg::ST_OK;
      rd_right <= from_right;
      if (is_push) begin
        if (full) begin
          st_q <= rdq_pkg::ST_FULL;
        end else begin
          if (to_right || empty) pr <= val_q;
          if (!to_right || empty) pl <= val_q;
        end
      end else if (is_pop) begin
        if (empty) begin
          st_q <= rdq_pkg::ST_EMPTY;
        end else begin
          pop_q <= from_right ? pr : pl;
        end
      end
    end else if (cmd.capture) begin
      if (rd_right) begin
        pr <= mem_rdata;
      end else begin
        pl <= mem_rdata;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      popped_value <= pop_q;
      left_value   <= empty ? '0 : (rev ? pr : pl);
      right_value  <= empty ? '0 : (rev ? pl : pr);
      count        <= cnt;
      is_empty     <= empty;
      status       <= st_q;
    end
  end

  // a refused push only happens with the ring full
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rdq_pkg::ST_FULL) |-> (count == CW'(DEPTH)))
    else $error("push refused while ring not full");

  // a refused pop reports an empty ring and no value
  a_empty_pop: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == rdq_pkg::ST_EMPTY) |-> (is_empty && popped_value == '0))
    else $error("pop refused while ring not empty");

  // empty flag follows the count
  a_empty_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  // stored count never exceeds the ring depth
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(DEPTH))
    else $error("count above ring depth");

endmodule

FILE: verif/deque_result_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// deque_result_checker
// Watches both channels of the reversible deque, keeps its own copy of the
// ring, head, fill level and reverse flag, predicts the result beat of every
// accepted operation and compares each delivered beat field by field.
// ---------------------------------------------------------------------------
module deque_result_checker #(
  parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [rdq_pkg::OP_W-1:0]          op,
  input  logic signed [rdq_pkg::DATA_W-1:0] value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic signed [rdq_pkg::DATA_W-1:0] popped_value,
  input  logic signed [rdq_pkg::DATA_W-1:0] left_value,
  input  logic signed [rdq_pkg::DATA_W-1:0] right_value,
  input  logic [$clog2(DEPTH+1)-1:0]        count,
  input  logic                              is_empty,
  input  logic [rdq_pkg::ST_W-1:0]          status,
  output int                                mismatches,
  output int                                outstanding
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = rdq_pkg::DATA_W;

  typedef struct packed {
    logic [DATA_W-1:0]        popped;
    logic [DATA_W-1:0]        left;
    logic [DATA_W-1:0]        right;
    logic [CNT_W-1:0]         fill;
    logic                     empty;
    logic [rdq_pkg::ST_W-1:0] st;
  } deque_result_t;

  // shadow of the deque contents
  logic [DATA_W-1:0] ring [DEPTH];
  logic [IDX_W-1:0]  head;
  logic [CNT_W-1:0]  fill;
  logic              flipped;

  deque_result_t predicted_results [$];
  deque_result_t want;

  // slot index at a given distance from the physical left end
  function automatic logic [IDX_W-1:0] slot_at(input int unsigned offset);
    return IDX_W'((int'(head) + offset) % DEPTH);
  endfunction

  // apply one operation to the shadow and return the beat it must produce
  function automatic deque_result_t step_deque(input logic [rdq_pkg::OP_W-1:0] code,
                                               input logic [DATA_W-1:0] v);
    deque_result_t res;
    logic          at_right;
    logic [DATA_W-1:0] phys_l;
    logic [DATA_W-1:0] phys_r;
    res.popped = '0;
    res.st     = rdq_pkg::ST_OK;
    case (code)
      rdq_pkg::OP_PUSH_L, rdq_pkg::OP_PUSH_R: begin
        if (int'(fill) >= DEPTH) begin
          res.st = rdq_pkg::ST_FULL;
        end else begin
          // a reversed deque pushes left at the physical right end
          at_right = (code == rdq_pkg::OP_PUSH_R) ^ flipped;
          if (at_right) begin
            ring[slot_at(fill)] = v;
          end else begin
            head = slot_at(DEPTH - 1);
            ring[head] = v;
          end
          fill = fill + 1'b1;
        end
      end
      rdq_pkg::OP_POP_L, rdq_pkg::OP_POP_R: begin
        if (fill == '0) begin
          res.st = rdq_pkg::ST_EMPTY;
        end else begin
          at_right = (code == rdq_pkg::OP_POP_R) ^ flipped;
          if (at_right) begin
            res.popped = ring[slot_at(fill - 1'b1)];
          end else begin
            res.popped = ring[head];
            head = slot_at(1);
          end
          fill = fill - 1'b1;
        end
      end
      rdq_pkg::OP_REV: flipped = ~flipped;
      default: ;
    endcase
    phys_l = '0;
    phys_r = '0;
    if (fill != '0) begin
      phys_l = ring[head];
      phys_r = ring[slot_at(fill - 1'b1)];
    end
    res.left  = flipped ? phys_r : phys_l;
    res.right = flipped ? phys_l : phys_r;
    res.fill  = fill;
    res.empty = (fill == '0);
    return res;
  endfunction

  task automatic check_field(input string name, input logic signed [DATA_W-1:0] exp_v,
                             input logic signed [DATA_W-1:0] got_v);
    if (got_v !== exp_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
      mismatches++;
    end
  endtask

  // compare the delivered beat first, then record the newly accepted one
  always @(posedge clk) begin
    if (rst) begin
      head    = '0;
      fill    = '0;
      flipped = 1'b0;
      predicted_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $error("result beat with no operation outstanding");
          mismatches++;
        end else begin
          want = predicted_results.pop_front();
          check_field("popped_value", $signed(want.popped), popped_value);
          check_field("left_value", $signed(want.left), left_value);
          check_field("right_value", $signed(want.right), right_value);
          check_field("count", DATA_W'(want.fill), DATA_W'(count));
          check_field("is_empty", DATA_W'(want.empty), DATA_W'(is_empty));
          check_field("status", DATA_W'(want.st), DATA_W'(status));
        end
      end
      if (in_valid && !in_stall) begin
        predicted_results.push_back(step_deque(op, value));
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb
// Stimulus and verdict for the reversible deque: directed corner cases and
// random operation streams under several sender and receiver idling mixes,
// checked by deque_result_checker.
// ---------------------------------------------------------------------------
module tb;

  localparam int DEPTH       = rdq_pkg::DEPTH_DEFAULT;
  localparam int OP_W        = rdq_pkg::OP_W;
  localparam int DATA_W      = rdq_pkg::DATA_W;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 250;

  // op codes the block ignores
  localparam logic [OP_W-1:0] OP_SPARE_5 = 3'd5;
  localparam logic [OP_W-1:0] OP_SPARE_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_7 = 3'd7;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic [OP_W-1:0] op = rdq_pkg::OP_REV;
  logic signed [DATA_W-1:0] value = '0;
  logic out_stall = 1'b0;
  logic in_stall;
  logic out_valid;
  logic signed [DATA_W-1:0] popped_value;
  logic signed [DATA_W-1:0] left_value;
  logic signed [DATA_W-1:0] right_value;
  logic [$clog2(DEPTH+1)-1:0] count;
  logic is_empty;
  logic [rdq_pkg::ST_W-1:0] status;

  int mismatches;
  int outstanding;
  int cycles = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_cnt = 0;

  always #6 clk = ~clk;

  reversible_deque #(.DEPTH(DEPTH)) uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .popped_value(popped_value), .left_value(left_value), .right_value(right_value),
    .count(count), .is_empty(is_empty), .status(status)
  );

  deque_result_checker #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .op(op), .value(value),
    .out_valid(out_valid), .out_stall(out_stall),
    .popped_value(popped_value), .left_value(left_value), .right_value(right_value),
    .count(count), .is_empty(is_empty), .status(status),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // receiver: long hold-off on request, random stalls otherwise
  always @(posedge clk) begin
    if (hold_seen != hold_reqs) begin
      hold_seen <= hold_reqs;
      hold_cnt  <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else if (hold_cnt != 0) begin
      hold_cnt  <= hold_cnt - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) cycles <= cycles + 1;

  initial begin
    while (cycles < CYCLE_LIMIT) @(posedge clk);
    $display("status: fail");
    $finish;
  end

  // offer one beat and hold it until taken
  task automatic send_op(input logic [OP_W-1:0] code, input logic [DATA_W-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= code;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and wait until every result beat has arrived
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  function automatic logic [DATA_W-1:0] rand_value();
    case ($urandom_range(15))
      0: return 64'h7FFF_FFFF_FFFF_FFFF;
      1: return 64'h8000_0000_0000_0000;
      2: return '1;
      3: return '0;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input int push_bias);
    int r;
    r = $urandom_range(99);
    if (r < 5) begin
      case ($urandom_range(2))
        0: return OP_SPARE_5;
        1: return OP_SPARE_6;
        default: return OP_SPARE_7;
      endcase
    end else if (r < 15) begin
      return rdq_pkg::OP_REV;
    end else if (r < 15 + push_bias * 85 / 100) begin
      return $urandom_range(1) ? rdq_pkg::OP_PUSH_R : rdq_pkg::OP_PUSH_L;
    end
    return $urandom_range(1) ? rdq_pkg::OP_POP_R : rdq_pkg::OP_POP_L;
  endfunction

  task automatic random_ops(input int n);
    int bias;
    bias = 50;
    for (int k = 0; k < n; k++) begin
      // swing the fill level up and down in bursts
      if (k % 20 == 0) bias = $urandom_range(1) ? 70 : 30;
      send_op(pick_op(bias), rand_value());
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed corners, no idling
    set_idling(0, 0);
    send_op(rdq_pkg::OP_POP_L, rand_value());
    send_op(rdq_pkg::OP_POP_R, rand_value());
    send_op(OP_SPARE_5, rand_value());
    send_op(rdq_pkg::OP_REV, rand_value());
    send_op(rdq_pkg::OP_POP_L, rand_value());
    send_op(rdq_pkg::OP_REV, rand_value());
    send_op(rdq_pkg::OP_PUSH_L, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(rdq_pkg::OP_PUSH_R, 64'h8000_0000_0000_0000);
    send_op(rdq_pkg::OP_PUSH_L, '1);
    send_op(rdq_pkg::OP_PUSH_R, '0);
    send_op(rdq_pkg::OP_POP_L, rand_value());
    send_op(rdq_pkg::OP_POP_R, rand_value());
    send_op(rdq_pkg::OP_REV, rand_value());
    send_op(rdq_pkg::OP_PUSH_L, 64'h5555_5555_5555_5555);
    send_op(rdq_pkg::OP_PUSH_R, 64'hAAAA_AAAA_AAAA_AAAA);
    send_op(OP_SPARE_6, '1);
    send_op(OP_SPARE_7, '1);
    send_op(rdq_pkg::OP_POP_L, rand_value());
    send_op(rdq_pkg::OP_POP_R, rand_value());
    send_op(rdq_pkg::OP_REV, rand_value());
    send_op(rdq_pkg::OP_POP_L, rand_value());
    send_op(rdq_pkg::OP_POP_R, rand_value());
    send_op(rdq_pkg::OP_POP_R, rand_value());

    random_ops(200);

    // receiver holds off while beats keep coming, then the sender waits
    hold_reqs <= hold_reqs + 1;
    random_ops(40);
    drain_results();

    set_idling(59, 0);
    random_ops(150);
    drain_results();
    set_idling(0, 59);
    random_ops(150);
    drain_results();
    set_idling(10, 10);
    random_ops(150);
    drain_results();
    set_idling(0, 0);
    random_ops(150);
    drain_results();

    // let any stray beat show up before the verdict
    repeat (20) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
